[rtl/ljls_pkg.sv]
// shared types and constants for the latency, jitter and loss statistics block
// no dependencies; used by latency_jitter_loss_stats and ljls_cmul
package ljls_pkg;

    localparam int CMD_W    = 2;
    localparam int LAT_IN_W = 32;
    localparam int BYTES_W  = 11;
    localparam int LOSS_W   = 14;
    localparam int AVG_W    = 32;
    localparam int BITS_W   = 40;
    localparam int COUNT_W  = 32;
    localparam int SUM_W    = 64;

    // loss is reported in hundredths of a percent
    localparam int SCALE_W = 14;
    localparam logic [SCALE_W-1:0] LOSS_SCALE = 14'd10000;
    localparam logic [LOSS_W-1:0]  LOSS_MAX   = 14'd10000;

    typedef enum logic [CMD_W-1:0] {
        CMD_INGRESS = 2'd0,
        CMD_MATCHED = 2'd1,
        CMD_LOST    = 2'd2,
        CMD_TICK    = 2'd3
    } cmd_t;

endpackage

[rtl/latency_jitter_loss_stats.sv]
// top level of the packet latency, jitter and loss statistics block
// depends on ljls_pkg, ljls_cmul and ljls_sdiv
//
// input channel (in_valid/in_ready) carries packet events: cmd, latency_ns,
// payload_bytes. ingress and lost events are taken back to back; a matched
// event blocks the input while the jitter sum is updated in the cycle after it.
// an interval tick starts two serial 64/32 dividers for the averages and,
// when the loss needs a division, a constant multiplier followed by a 78-bit
// divider for the loss; the loss path then sets the tick time, otherwise
// the average dividers do. no item is taken while a tick is in progress.
// output channel (out_valid/out_ready) holds one result in an output
// register. events keep flowing while that result waits; a later tick
// finishes its arithmetic and then waits until the register is free.
// reset clears all counters and sums and leaves the block idle with no
// result pending.
module latency_jitter_loss_stats #(
    parameter int LATENCY_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ljls_pkg::CMD_W-1:0]    cmd,
    input  logic [ljls_pkg::LAT_IN_W-1:0] latency_ns,
    input  logic [ljls_pkg::BYTES_W-1:0]  payload_bytes,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ljls_pkg::LOSS_W-1:0]   loss_centipercent,
    output logic [ljls_pkg::AVG_W-1:0]    avg_latency_ns,
    output logic [ljls_pkg::AVG_W-1:0]    avg_jitter_ns,
    output logic [ljls_pkg::BITS_W-1:0]   payload_bits,
    output logic [ljls_pkg::COUNT_W-1:0]  matched_count
);

    localparam int LAT_W  = (LATENCY_BITS < ljls_pkg::LAT_IN_W) ? LATENCY_BITS
                                                                : ljls_pkg::LAT_IN_W;
    localparam int SUM_W  = ljls_pkg::SUM_W;
    localparam int CNT_W  = ljls_pkg::COUNT_W;
    localparam int BITS_W = ljls_pkg::BITS_W;
    localparam int AVG_W  = ljls_pkg::AVG_W;
    localparam int LOSS_W = ljls_pkg::LOSS_W;
    localparam int PROD_W = SUM_W + ljls_pkg::SCALE_W;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_WAIT = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    typedef enum logic [1:0] {
        LM_ZERO = 2'd0,
        LM_FULL = 2'd1,
        LM_DIV  = 2'd2
    } loss_mode_t;

    state_t     state_reg, state_next;
    loss_mode_t loss_mode_reg, loss_mode_next;

    logic [SUM_W-1:0]  ingress_reg, ingress_next;
    logic [SUM_W-1:0]  loss_reg, loss_next;
    logic [CNT_W-1:0]  match_reg, match_next;
    logic [SUM_W-1:0]  lat_sum_reg, lat_sum_next;
    logic [SUM_W-1:0]  jit_sum_reg, jit_sum_next;
    logic [LAT_W-1:0]  prev_lat_reg, prev_lat_next;
    logic [LAT_W-1:0]  diff_reg, diff_next;
    logic              jit_pend_reg, jit_pend_next;
    logic [BITS_W-1:0] bit_sum_reg, bit_sum_next;

    logic [BITS_W-1:0] bits_snap_reg;
    logic [CNT_W-1:0]  count_snap_reg;
    logic              lat_zero_reg;
    logic              jit_zero_reg;

    logic              out_valid_reg, out_valid_next;
    logic [LOSS_W-1:0] loss_out_reg;
    logic [AVG_W-1:0]  lat_out_reg;
    logic [AVG_W-1:0]  jit_out_reg;
    logic [BITS_W-1:0] bits_out_reg;
    logic [CNT_W-1:0]  count_out_reg;

    logic              accept;
    logic              tick_acc;
    logic              out_load;
    ljls_pkg::cmd_t    cmd_in;
    logic [LAT_W-1:0]  lat;
    logic [LAT_W-1:0]  lat_diff;
    logic [SUM_W:0]    lat_add;
    logic [SUM_W:0]    jit_add;
    logic [BITS_W:0]   bit_add;

    logic              lat_busy, jit_busy, loss_busy, mul_done;
    logic [SUM_W-1:0]  lat_q, jit_q;
    logic [PROD_W-1:0] loss_q;
    logic [PROD_W-1:0] prod;
    logic [CNT_W-1:0]  jit_den;

    logic [LOSS_W-1:0] loss_res;
    logic [AVG_W-1:0]  lat_res;
    logic [AVG_W-1:0]  jit_res;

    assign in_ready = (state_reg == ST_IDLE) && !jit_pend_reg;
    assign accept   = in_valid && in_ready;
    assign cmd_in   = ljls_pkg::cmd_t'(cmd);
    assign tick_acc = accept && (cmd_in == ljls_pkg::CMD_TICK);
    assign lat      = latency_ns[LAT_W-1:0];
    assign lat_diff = (lat >= prev_lat_reg) ? lat - prev_lat_reg : prev_lat_reg - lat;
    assign lat_add  = {1'b0, lat_sum_reg} + (SUM_W + 1)'(lat);
    assign jit_add  = {1'b0, jit_sum_reg} + (SUM_W + 1)'(diff_reg);
    assign bit_add  = {1'b0, bit_sum_reg} + (BITS_W + 1)'({payload_bytes, 3'b000});
    assign jit_den  = match_reg - 1'b1;

    // event accumulators
    always_comb
    begin
        ingress_next   = ingress_reg;
        loss_next      = loss_reg;
        match_next     = match_reg;
        lat_sum_next   = lat_sum_reg;
        jit_sum_next   = jit_sum_reg;
        prev_lat_next  = prev_lat_reg;
        diff_next      = diff_reg;
        jit_pend_next  = 1'b0;
        bit_sum_next   = bit_sum_reg;
        loss_mode_next = loss_mode_reg;

        if (jit_pend_reg)
        begin
            jit_sum_next = jit_add[SUM_W] ? '1 : jit_add[SUM_W-1:0];
        end

        if (accept)
        begin
            case (cmd_in)
                ljls_pkg::CMD_INGRESS:
                begin
                    ingress_next = (&ingress_reg) ? ingress_reg : ingress_reg + 1'b1;
                end
                ljls_pkg::CMD_MATCHED:
                begin
                    match_next    = (&match_reg) ? match_reg : match_reg + 1'b1;
                    lat_sum_next  = lat_add[SUM_W] ? '1 : lat_add[SUM_W-1:0];
                    diff_next     = lat_diff;
                    jit_pend_next = 1'b1;
                    prev_lat_next = lat;
                    bit_sum_next  = bit_add[BITS_W] ? '1 : bit_add[BITS_W-1:0];
                end
                ljls_pkg::CMD_LOST:
                begin
                    loss_next = (&loss_reg) ? loss_reg : loss_reg + 1'b1;
                end
                ljls_pkg::CMD_TICK:
                begin
                    match_next   = '0;
                    lat_sum_next = '0;
                    jit_sum_next = '0;
                    bit_sum_next = '0;
                    if (ingress_reg == '0)
                    begin
                        loss_mode_next = LM_ZERO;
                    end
                    else if (loss_reg >= ingress_reg)
                    begin
                        loss_mode_next = LM_FULL;
                    end
                    else
                    begin
                        loss_mode_next = LM_DIV;
                    end
                end
                default:
                begin
                    match_next = match_reg;
                end
            endcase
        end
    end

    // tick sequencing
    always_comb
    begin
        state_next = state_reg;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (tick_acc)
                begin
                    state_next = (loss_mode_next == LM_DIV) ? ST_MUL : ST_WAIT;
                end
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (!lat_busy && !jit_busy && !loss_busy)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_comb
    begin
        case (loss_mode_reg)
            LM_ZERO: loss_res = '0;
            LM_FULL: loss_res = ljls_pkg::LOSS_MAX;
            LM_DIV:  loss_res = loss_q[LOSS_W-1:0];
            default: loss_res = '0;
        endcase
        if (lat_zero_reg)
        begin
            lat_res = '0;
        end
        else
        begin
            lat_res = (|lat_q[SUM_W-1:AVG_W]) ? '1 : lat_q[AVG_W-1:0];
        end
        if (jit_zero_reg)
        begin
            jit_res = '0;
        end
        else
        begin
            jit_res = (|jit_q[SUM_W-1:AVG_W]) ? '1 : jit_q[AVG_W-1:0];
        end
    end

    ljls_sdiv #(
        .N_W (SUM_W),
        .D_W (CNT_W)
    ) u_lat_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (tick_acc),
        .dividend (lat_sum_reg),
        .divisor  (match_reg),
        .busy     (lat_busy),
        .quotient (lat_q)
    );

    ljls_sdiv #(
        .N_W (SUM_W),
        .D_W (CNT_W)
    ) u_jit_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (tick_acc),
        .dividend (jit_sum_reg),
        .divisor  (jit_den),
        .busy     (jit_busy),
        .quotient (jit_q)
    );

    ljls_cmul #(
        .A_W (SUM_W)
    ) u_loss_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (tick_acc && (loss_mode_next == LM_DIV)),
        .a     (loss_reg),
        .done  (mul_done),
        .prod  (prod)
    );

    ljls_sdiv #(
        .N_W (PROD_W),
        .D_W (SUM_W)
    ) u_loss_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mul_done),
        .dividend (prod),
        .divisor  (ingress_reg),
        .busy     (loss_busy),
        .quotient (loss_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            loss_mode_reg <= LM_ZERO;
            ingress_reg   <= '0;
            loss_reg      <= '0;
            match_reg     <= '0;
            lat_sum_reg   <= '0;
            jit_sum_reg   <= '0;
            prev_lat_reg  <= '0;
            diff_reg      <= '0;
            jit_pend_reg  <= 1'b0;
            bit_sum_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            loss_mode_reg <= loss_mode_next;
            ingress_reg   <= ingress_next;
            loss_reg      <= loss_next;
            match_reg     <= match_next;
            lat_sum_reg   <= lat_sum_next;
            jit_sum_reg   <= jit_sum_next;
            prev_lat_reg  <= prev_lat_next;
            diff_reg      <= diff_next;
            jit_pend_reg  <= jit_pend_next;
            bit_sum_reg   <= bit_sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_acc)
        begin
            bits_snap_reg  <= bit_sum_reg;
            count_snap_reg <= match_reg;
            lat_zero_reg   <= (match_reg == '0);
            jit_zero_reg   <= (match_reg <= CNT_W'(1));
        end
        if (out_load)
        begin
            loss_out_reg  <= loss_res;
            lat_out_reg   <= lat_res;
            jit_out_reg   <= jit_res;
            bits_out_reg  <= bits_snap_reg;
            count_out_reg <= count_snap_reg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign loss_centipercent = loss_out_reg;
    assign avg_latency_ns    = lat_out_reg;
    assign avg_jitter_ns     = jit_out_reg;
    assign payload_bits      = bits_out_reg;
    assign matched_count     = count_out_reg;

    a_idle_units_quiet : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!lat_busy && !jit_busy && !loss_busy))
        else $error("arithmetic unit busy while idle");

    a_tick_clears : assert property (@(posedge clk) disable iff (!rst_n)
        tick_acc |=> (match_reg == '0 && lat_sum_reg == '0 && bit_sum_reg == '0))
        else $error("interval sums not cleared after tick");

    a_mul_done_in_mul : assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == ST_MUL))
        else $error("loss multiply finished outside its state");

    a_loss_range : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (loss_out_reg <= ljls_pkg::LOSS_MAX))
        else $error("loss result above full scale");

endmodule

[rtl/ljls_cmul.sv]
// bit-serial multiply by the loss scale constant, one constant bit per cycle
// depends on ljls_pkg
module ljls_cmul #(
    parameter int A_W = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [A_W-1:0]                  a,
    output logic                            done,
    output logic [A_W+ljls_pkg::SCALE_W-1:0] prod
);

    localparam int P_W   = A_W + ljls_pkg::SCALE_W;
    localparam int IDX_W = $clog2(ljls_pkg::SCALE_W);

    logic [A_W-1:0]   a_reg;
    logic [P_W-1:0]   acc_reg;
    logic [P_W-1:0]   acc_next;
    logic [P_W-1:0]   addend;
    logic [IDX_W-1:0] idx_reg;
    logic             busy_reg;
    logic             done_reg;

    // msb first shift and add
    always_comb
    begin
        addend   = ljls_pkg::LOSS_SCALE[idx_reg] ? P_W'(a_reg) : '0;
        acc_next = {acc_reg[P_W-2:0], 1'b0} + addend;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            idx_reg  <= IDX_W'(ljls_pkg::SCALE_W - 1);
        end
        else if (busy_reg)
        begin
            if (idx_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                idx_reg  <= idx_reg - 1'b1;
                done_reg <= 1'b0;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

[rtl/ljls_sdiv.sv]
// radix-2 restoring divider, one quotient bit per cycle, dividend shifted msb first
// no dependencies
module ljls_sdiv #(
    parameter int N_W = 64,
    parameter int D_W = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N_W-1:0] dividend,
    input  logic [D_W-1:0] divisor,
    output logic           busy,
    output logic [N_W-1:0] quotient
);

    localparam int CNT_W = $clog2(N_W);

    logic [N_W-1:0]   dvd_reg;
    logic [D_W-1:0]   rem_reg;
    logic [D_W-1:0]   den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;

    logic [D_W:0]     shifted;
    logic [D_W:0]     diff;
    logic             ge;

    always_comb
    begin
        shifted = {rem_reg, dvd_reg[N_W-1]};
        ge      = shifted >= {1'b0, den_reg};
        diff    = shifted - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(N_W - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // quotient bits shift in behind the dividend
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[N_W-2:0], ge};
            rem_reg <= ge ? diff[D_W-1:0] : shifted[D_W-1:0];
        end
    end

    assign busy     = busy_reg;
    assign quotient = dvd_reg;

endmodule
